/* hdl/ncofs_pkg.sv */
// Shared constants, types and arctangent table of the NCO complex frequency shifter.
package ncofs_pkg;

    // Phase accumulator and shift word
    localparam int PHASE_W = 18;
    localparam int SHIFT_W = 18;

    // Phase modulus, kept as odd factor times a power of two
    localparam int MOD_ODD       = 375;
    localparam int MOD_POW       = 9;
    localparam int PHASE_MODULUS = MOD_ODD << MOD_POW;

    // Turn fraction: angle = floor(phase * 2^ANGLE_W / PHASE_MODULUS)
    localparam int ANGLE_W = 32;
    localparam longint unsigned RECIP_BASE  = (64'd1 << (ANGLE_W - MOD_POW)) / MOD_ODD;
    localparam longint unsigned RECIP_REM   = (64'd1 << (ANGLE_W - MOD_POW)) % MOD_ODD;
    localparam int              RECIP_SHIFT = 34;
    localparam longint unsigned RECIP_MUL   = (64'd1 << RECIP_SHIFT) / MOD_ODD;
    localparam int FRAC_W = $clog2(RECIP_REM * PHASE_MODULUS);
    localparam int EST_W  = $clog2(RECIP_REM * PHASE_MODULUS / MOD_ODD + 1);
    localparam int RMUL_W = $clog2(RECIP_MUL + 1);

    // CORDIC datapath (Q2.30 x/y, angle in 2^-32 turn)
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 33;
    localparam int CORDIC_GAIN  = 652032874;

    localparam logic [ANGLE_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Coefficients: Q1.15 with one guard bit so negation stays exact
    localparam int COEF_W     = 17;
    localparam int FRAC_BITS  = 15;
    localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);
    localparam int COEF_MAX   = (1 << FRAC_BITS) - 1;

    typedef enum logic {
        ACT_MIX     = 1'b0,
        ACT_DISCARD = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quad;

    typedef struct packed {
        logic [CORDIC_W-1:0] x;
        logic [CORDIC_W-1:0] y;
        logic [CORDIC_W-1:0] z;
        t_quad               quad;
    } t_cordic;

endpackage

/* hdl/ncofs_angle.sv */
// Phase accumulator and phase-to-angle conversion feeding the CORDIC chain.
module ncofs_angle #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_accept,
    input  logic                                  i_action,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_sample_im,
    input  logic signed [ncofs_pkg::SHIFT_W-1:0]  i_shift_hz,
    output logic                                  o_valid,
    output ncofs_pkg::t_cordic                    o_state,
    output logic signed [SAMPLE_WIDTH-1:0]        o_re,
    output logic signed [SAMPLE_WIDTH-1:0]        o_im
);

    localparam int PW     = ncofs_pkg::PHASE_W;
    localparam int AW     = ncofs_pkg::ANGLE_W;
    localparam int FW     = ncofs_pkg::FRAC_W;
    localparam int EW     = ncofs_pkg::EST_W;
    localparam int CW     = ncofs_pkg::CORDIC_W;
    localparam int DIFF_W = PW + 2;
    localparam int PROD_W = FW + ncofs_pkg::RMUL_W;

    localparam logic signed [DIFF_W-1:0] MOD_S   = DIFF_W'(ncofs_pkg::PHASE_MODULUS);
    localparam logic [AW-1:0]            K_BASE  = AW'(ncofs_pkg::RECIP_BASE);
    localparam logic [FW-1:0]            K_REM   = FW'(ncofs_pkg::RECIP_REM);
    localparam logic [PROD_W-1:0]        K_MUL   = PROD_W'(ncofs_pkg::RECIP_MUL);
    localparam logic [FW-1:0]            K_ODD   = FW'(ncofs_pkg::MOD_ODD);
    localparam logic [AW-1:0]            K_EIGHTH = AW'(64'd1 << (AW - 3));

    logic                    w_mix;
    logic signed [DIFF_W-1:0] w_diff;
    logic [PW-1:0]           r_phase;
    logic [PW-1:0]           n_phase;

    logic                    r_s1_valid;
    logic [AW-1:0]           r_s1_base;
    logic [FW-1:0]           r_s1_frac;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_re, r_s1_im;

    logic [PROD_W-1:0]       w_prod;
    logic                    r_s2_valid;
    logic [AW-1:0]           r_s2_base;
    logic [FW-1:0]           r_s2_frac;
    logic [EW-1:0]           r_s2_est;
    logic signed [SAMPLE_WIDTH-1:0] r_s2_re, r_s2_im;

    logic [FW-1:0]           w_rem;
    logic                    w_inc;
    logic                    r_s3_valid;
    logic [AW-1:0]           r_s3_angle;
    logic signed [SAMPLE_WIDTH-1:0] r_s3_re, r_s3_im;

    logic [AW-1:0]           w_round;
    logic [1:0]              w_quad;
    logic [AW-1:0]           w_resid;
    ncofs_pkg::t_cordic      n_state;
    logic                    r_s4_valid;
    ncofs_pkg::t_cordic      r_s4_state;
    logic signed [SAMPLE_WIDTH-1:0] r_s4_re, r_s4_im;

    assign w_mix = i_accept && (i_action == ncofs_pkg::ACT_MIX);

    // Phase step with one wrap; covers the whole shift word range
    assign w_diff = $signed({2'b00, r_phase})
                  - $signed({{2{i_shift_hz[ncofs_pkg::SHIFT_W-1]}}, i_shift_hz});

    always_comb begin
        if (w_diff[DIFF_W-1]) begin
            n_phase = PW'(w_diff + MOD_S);
        end else if (w_diff >= MOD_S) begin
            n_phase = PW'(w_diff - MOD_S);
        end else begin
            n_phase = PW'(w_diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_mix) begin
            r_phase <= n_phase;
        end
    end

    // Stage 1: phase * 2^23 / 375 split into whole part and remainder term
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= w_mix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_base <= AW'(r_phase * K_BASE);
            r_s1_frac <= FW'(r_phase * K_REM);
            r_s1_re   <= i_sample_re;
            r_s1_im   <= i_sample_im;
        end
    end

    // Stage 2: reciprocal estimate of frac / 375, low by at most one
    assign w_prod = PROD_W'(r_s1_frac) * K_MUL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_base <= r_s1_base;
            r_s2_frac <= r_s1_frac;
            r_s2_est  <= w_prod[ncofs_pkg::RECIP_SHIFT +: EW];
            r_s2_re   <= r_s1_re;
            r_s2_im   <= r_s1_im;
        end
    end

    // Stage 3: correct the estimate and form the turn fraction
    assign w_rem = r_s2_frac - FW'(r_s2_est * K_ODD);
    assign w_inc = (w_rem >= K_ODD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_angle <= r_s2_base + AW'(r_s2_est) + AW'(w_inc);
            r_s3_re    <= r_s2_re;
            r_s3_im    <= r_s2_im;
        end
    end

    // Stage 4: nearest quarter turn and signed residue, CORDIC start vector
    assign w_round = r_s3_angle + K_EIGHTH;
    assign w_quad  = w_round[AW-1 -: 2];
    assign w_resid = r_s3_angle - {w_quad, (AW-2)'(0)};

    always_comb begin
        n_state.x    = CW'(ncofs_pkg::CORDIC_GAIN);
        n_state.y    = '0;
        n_state.z    = {{(CW-AW){w_resid[AW-1]}}, w_resid};
        n_state.quad = ncofs_pkg::t_quad'(w_quad);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_state <= n_state;
            r_s4_re    <= r_s3_re;
            r_s4_im    <= r_s3_im;
        end
    end

    assign o_valid = r_s4_valid;
    assign o_state = r_s4_state;
    assign o_re    = r_s4_re;
    assign o_im    = r_s4_im;

endmodule

/* hdl/ncofs_cordic_cell.sv */
// One CORDIC rotation cell: a single micro-rotation, registered, sample carried alongside.
module ncofs_cordic_cell #(
    parameter int STEP         = 0,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  ncofs_pkg::t_cordic             i_state,
    input  logic signed [SAMPLE_WIDTH-1:0] i_re,
    input  logic signed [SAMPLE_WIDTH-1:0] i_im,
    output logic                           o_valid,
    output ncofs_pkg::t_cordic             o_state,
    output logic signed [SAMPLE_WIDTH-1:0] o_re,
    output logic signed [SAMPLE_WIDTH-1:0] o_im
);

    localparam int CW = ncofs_pkg::CORDIC_W;
    localparam logic signed [CW-1:0] ATAN_K = CW'(ncofs_pkg::ATAN_TURN[STEP]);

    logic signed [CW-1:0] w_x, w_y, w_z, w_dx, w_dy;
    ncofs_pkg::t_cordic   n_state;
    logic                 r_valid;
    ncofs_pkg::t_cordic   r_state;
    logic signed [SAMPLE_WIDTH-1:0] r_re, r_im;

    assign w_x  = $signed(i_state.x);
    assign w_y  = $signed(i_state.y);
    assign w_z  = $signed(i_state.z);
    assign w_dx = w_y >>> STEP;
    assign w_dy = w_x >>> STEP;

    // Rotate towards zero residual angle
    always_comb begin
        n_state.quad = i_state.quad;
        if (!w_z[CW-1]) begin
            n_state.x = w_x - w_dx;
            n_state.y = w_y + w_dy;
            n_state.z = w_z - ATAN_K;
        end else begin
            n_state.x = w_x + w_dx;
            n_state.y = w_y - w_dy;
            n_state.z = w_z + ATAN_K;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
            r_re    <= i_re;
            r_im    <= i_im;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_re    = r_re;
    assign o_im    = r_im;

endmodule

/* hdl/ncofs_mixer.sv */
// Coefficient rounding, complex multiply, output rounding and output register with flow control.
module ncofs_mixer #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  ncofs_pkg::t_cordic             i_state,
    input  logic signed [SAMPLE_WIDTH-1:0] i_re,
    input  logic signed [SAMPLE_WIDTH-1:0] i_im,
    input  logic                           i_stall,
    output logic                           o_en,
    output logic                           o_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_mixed_re,
    output logic signed [SAMPLE_WIDTH-1:0] o_mixed_im
);

    localparam int CW     = ncofs_pkg::CORDIC_W;
    localparam int KW     = ncofs_pkg::COEF_W;
    localparam int PROD_W = SAMPLE_WIDTH + KW;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic signed [CW-1:0]    C_BIAS = CW'(ncofs_pkg::ROUND_BIAS);
    localparam logic signed [CW-1:0]    C_MAX  = CW'(ncofs_pkg::COEF_MAX);
    localparam logic signed [CW-1:0]    C_MIN  = ~C_MAX;
    localparam logic signed [SUM_W-1:0] S_BIAS = SUM_W'(ncofs_pkg::ROUND_BIAS);
    localparam logic signed [SUM_W-1:0] S_MAX  =
        {{(SUM_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] S_MIN  = ~S_MAX;

    logic                 w_out_free;
    logic                 w_en;

    logic signed [CW-1:0] w_xr, w_yr;
    logic signed [KW-1:0] w_xc, w_yc;
    logic signed [KW-1:0] n_cos, n_sin;
    logic                 r_c_valid;
    logic signed [KW-1:0] r_cos, r_sin;
    logic signed [SAMPLE_WIDTH-1:0] r_c_re, r_c_im;

    logic                     r_p_valid;
    logic signed [PROD_W-1:0] r_p_rc, r_p_is, r_p_rs, r_p_ic;

    logic signed [SUM_W-1:0] w_re_sum, w_im_sum, w_re_rnd, w_im_rnd;
    logic signed [SAMPLE_WIDTH-1:0] n_out_re, n_out_im;
    logic                    r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_re, r_out_im;

    // Pipeline moves unless a finished beat waits behind a stalled output
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_en       = w_out_free || !r_p_valid;

    // Round x, y to Q1.15 and saturate
    assign w_xr = ($signed(i_state.x) + C_BIAS) >>> ncofs_pkg::FRAC_BITS;
    assign w_yr = ($signed(i_state.y) + C_BIAS) >>> ncofs_pkg::FRAC_BITS;

    always_comb begin
        if (w_xr > C_MAX) begin
            w_xc = KW'(C_MAX);
        end else if (w_xr < C_MIN) begin
            w_xc = KW'(C_MIN);
        end else begin
            w_xc = KW'(w_xr);
        end
        if (w_yr > C_MAX) begin
            w_yc = KW'(C_MAX);
        end else if (w_yr < C_MIN) begin
            w_yc = KW'(C_MIN);
        end else begin
            w_yc = KW'(w_yr);
        end
    end

    // Undo the quarter-turn reduction
    always_comb begin
        unique case (i_state.quad)
            ncofs_pkg::QUAD_0: begin
                n_cos = w_xc;
                n_sin = w_yc;
            end
            ncofs_pkg::QUAD_90: begin
                n_cos = -w_yc;
                n_sin = w_xc;
            end
            ncofs_pkg::QUAD_180: begin
                n_cos = -w_xc;
                n_sin = -w_yc;
            end
            ncofs_pkg::QUAD_270: begin
                n_cos = w_yc;
                n_sin = -w_xc;
            end
            default: begin
                n_cos = w_xc;
                n_sin = w_yc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= i_valid;
            r_p_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cos  <= n_cos;
            r_sin  <= n_sin;
            r_c_re <= i_re;
            r_c_im <= i_im;
            r_p_rc <= r_c_re * r_cos;
            r_p_is <= r_c_im * r_sin;
            r_p_rs <= r_c_re * r_sin;
            r_p_ic <= r_c_im * r_cos;
        end
    end

    // Combine, round half up and saturate to the sample range
    assign w_re_sum = SUM_W'(r_p_rc) - SUM_W'(r_p_is);
    assign w_im_sum = SUM_W'(r_p_rs) + SUM_W'(r_p_ic);
    assign w_re_rnd = (w_re_sum + S_BIAS) >>> ncofs_pkg::FRAC_BITS;
    assign w_im_rnd = (w_im_sum + S_BIAS) >>> ncofs_pkg::FRAC_BITS;

    always_comb begin
        if (w_re_rnd > S_MAX) begin
            n_out_re = SAMPLE_WIDTH'(S_MAX);
        end else if (w_re_rnd < S_MIN) begin
            n_out_re = SAMPLE_WIDTH'(S_MIN);
        end else begin
            n_out_re = SAMPLE_WIDTH'(w_re_rnd);
        end
        if (w_im_rnd > S_MAX) begin
            n_out_im = SAMPLE_WIDTH'(S_MAX);
        end else if (w_im_rnd < S_MIN) begin
            n_out_im = SAMPLE_WIDTH'(S_MIN);
        end else begin
            n_out_im = SAMPLE_WIDTH'(w_im_rnd);
        end
    end

    // Output register: loads whenever its beat is empty or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_re <= n_out_re;
            r_out_im <= n_out_im;
        end
    end

    assign o_en       = w_en;
    assign o_valid    = r_out_valid;
    assign o_mixed_re = r_out_re;
    assign o_mixed_im = r_out_im;

endmodule

/* hdl/nco_complex_frequency_shifter_top.sv */
// Top level of the NCO complex frequency shifter: angle front end, CORDIC cell row, mixer.
//
// Input channel (i_valid / o_stall): one complex Q1.15 sample per beat with an action
// and a phase step. A mix beat is rotated by the current NCO phase and the phase then
// steps down by i_shift_hz modulo 192000; a discard beat is dropped, no result, and
// the phase is kept.
// Output channel (o_valid / i_stall): one rotated, rounded, saturated sample per mix beat,
// in input order.
// Throughput: one beat per cycle while o_stall is low; the next phase is formed combinationally
// from the phase register. Pipeline: 4 angle stages, 24 CORDIC cells, coefficient stage,
// product stage, output register.
// Stall: the row advances as long as the output register is free or the product stage
// is empty, so bubbles close up behind a stalled output; o_stall rises only when a
// finished beat sits in the product stage behind a held output.
// Reset (synchronous, active low): phase to zero, all stage valids cleared.
module nco_complex_frequency_shifter_top #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_action,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_sample_im,
    input  logic signed [ncofs_pkg::SHIFT_W-1:0] i_shift_hz,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]       o_mixed_re,
    output logic signed [SAMPLE_WIDTH-1:0]       o_mixed_im
);

    localparam int NSTEP = ncofs_pkg::CORDIC_STEPS;

    logic                           w_en;
    logic                           w_accept;
    logic                           w_valid [NSTEP+1];
    ncofs_pkg::t_cordic             w_state [NSTEP+1];
    logic signed [SAMPLE_WIDTH-1:0] w_re    [NSTEP+1];
    logic signed [SAMPLE_WIDTH-1:0] w_im    [NSTEP+1];

    assign o_stall  = !w_en;
    assign w_accept = i_valid && w_en;

    // Phase accumulator and angle conversion
    ncofs_angle #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_angle (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_accept    (w_accept),
        .i_action    (i_action),
        .i_sample_re (i_sample_re),
        .i_sample_im (i_sample_im),
        .i_shift_hz  (i_shift_hz),
        .o_valid     (w_valid[0]),
        .o_state     (w_state[0]),
        .o_re        (w_re[0]),
        .o_im        (w_im[0])
    );

    // Row of CORDIC cells, one micro-rotation each
    for (genvar g = 0; g < NSTEP; g++) begin : g_cell
        ncofs_cordic_cell #(
            .STEP         (g),
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_state (w_state[g]),
            .i_re    (w_re[g]),
            .i_im    (w_im[g]),
            .o_valid (w_valid[g+1]),
            .o_state (w_state[g+1]),
            .o_re    (w_re[g+1]),
            .o_im    (w_im[g+1])
        );
    end

    // Complex multiply and output beat
    ncofs_mixer #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_mixer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid[NSTEP]),
        .i_state    (w_state[NSTEP]),
        .i_re       (w_re[NSTEP]),
        .i_im       (w_im[NSTEP]),
        .i_stall    (i_stall),
        .o_en       (w_en),
        .o_valid    (o_valid),
        .o_mixed_re (o_mixed_re),
        .o_mixed_im (o_mixed_im)
    );

endmodule

/* hdl/ncofs_checker.sv */
// Port-level checks for the NCO complex frequency shifter, bound to the top level.
module ncofs_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_stall,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic signed [SAMPLE_WIDTH-1:0] o_mixed_re,
    input logic signed [SAMPLE_WIDTH-1:0] o_mixed_im
);

    // Input is held back only behind a full, stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output beat free");

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_mixed_re) && $stable(o_mixed_im)))
        else $error("stalled output beat changed");

    // Nothing leaves on the first cycle out of reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_valid)
        else $error("output valid straight after reset");

endmodule

bind nco_complex_frequency_shifter_top ncofs_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_ncofs_checker (.*);

/* verif/nco_complex_frequency_shifter_top_tb.sv */
// Self-checking testbench for the NCO complex frequency shifter: phase predictor, scoreboard, drivers.
`timescale 1ns / 100ps

package ncofs_tb_pkg;

    localparam int SW = 16;

    // Arctangent steps in units of 2^-32 turn
    localparam longint NCO_ATAN [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct {
        logic signed [SW-1:0] re;
        logic signed [SW-1:0] im;
    } t_mix_result;

    // Tracks the NCO phase and holds the rotated samples still to come out
    class mix_scoreboard;
        int unsigned nco_phase;
        t_mix_result expected_mix[$];
        int unsigned n_mixed;
        int unsigned n_discarded;
        int unsigned n_checked;
        int unsigned n_errors;

        function new();
            nco_phase   = 0;
            n_mixed     = 0;
            n_discarded = 0;
            n_checked   = 0;
            n_errors    = 0;
        endfunction

        static function longint clamp16(longint v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        // cos/sin of the current phase in Q1.15 via quadrant fold and CORDIC
        function void nco_phasor(output longint c, output longint s);
            longint unsigned turn;
            logic [31:0]     a32;
            logic [31:0]     r32;
            logic [1:0]      q;
            longint          x, y, z, dx, dy, xc, yc;
            turn = (longint'(nco_phase) << 32) / ncofs_pkg::PHASE_MODULUS;
            a32  = turn[31:0];
            q    = 2'((a32 + 32'h2000_0000) >> 30);
            r32  = a32 - {q, 30'd0};
            z    = longint'($signed(r32));
            x    = ncofs_pkg::CORDIC_GAIN;
            y    = 0;
            for (int k = 0; k < 24; k++) begin
                dx = y >>> k;
                dy = x >>> k;
                if (z >= 0) begin
                    x -= dx;
                    y += dy;
                    z -= NCO_ATAN[k];
                end else begin
                    x += dx;
                    y -= dy;
                    z += NCO_ATAN[k];
                end
            end
            xc = clamp16((x + 16384) >>> 15);
            yc = clamp16((y + 16384) >>> 15);
            case (ncofs_pkg::t_quad'(q))
                ncofs_pkg::QUAD_0: begin
                    c = xc;
                    s = yc;
                end
                ncofs_pkg::QUAD_90: begin
                    c = -yc;
                    s = xc;
                end
                ncofs_pkg::QUAD_180: begin
                    c = -xc;
                    s = -yc;
                end
                default: begin
                    c = yc;
                    s = -xc;
                end
            endcase
        endfunction

        // Accepted input beat: a discard is only counted; a mix is rotated, queued and steps the phase down
        function void note_input(logic act, logic signed [SW-1:0] sre, logic signed [SW-1:0] sim,
                                 logic signed [ncofs_pkg::SHIFT_W-1:0] shift);
            longint      c, s, sr, si, sh, next_phase;
            t_mix_result res;
            if (act == ncofs_pkg::ACT_DISCARD) begin
                n_discarded++;
                return;
            end
            sr = longint'(sre);
            si = longint'(sim);
            sh = longint'(shift);
            nco_phasor(c, s);
            res.re = SW'(clamp16((sr * c - si * s + 16384) >>> 15));
            res.im = SW'(clamp16((sr * s + si * c + 16384) >>> 15));
            expected_mix.push_back(res);
            n_mixed++;
            next_phase = (longint'(nco_phase) - sh) % ncofs_pkg::PHASE_MODULUS;
            if (next_phase < 0)
                next_phase += ncofs_pkg::PHASE_MODULUS;
            nco_phase = 32'(next_phase);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            n_errors++;
        endtask

        // Output beat against the oldest pending product
        task check_result(logic signed [SW-1:0] got_re, logic signed [SW-1:0] got_im);
            t_mix_result want;
            if (expected_mix.size() == 0) begin
                report($sformatf("output beat re=%0d im=%0d with nothing pending", got_re, got_im));
                return;
            end
            want = expected_mix.pop_front();
            n_checked++;
            if (got_re !== want.re)
                report($sformatf("beat %0d mixed_re got %0d want %0d", n_checked, got_re, want.re));
            if (got_im !== want.im)
                report($sformatf("beat %0d mixed_im got %0d want %0d", n_checked, got_im, want.im));
        endtask

        function int pending();
            return expected_mix.size();
        endfunction
    endclass

endpackage

module nco_complex_frequency_shifter_top_tb;

    localparam int SW           = ncofs_tb_pkg::SW;
    localparam int SHW          = ncofs_pkg::SHIFT_W;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 250;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  i_action    = ncofs_pkg::ACT_MIX;
    logic signed [SW-1:0]  i_sample_re = '0;
    logic signed [SW-1:0]  i_sample_im = '0;
    logic signed [SHW-1:0] i_shift_hz  = '0;
    logic                  i_stall     = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic signed [SW-1:0]  o_mixed_re;
    logic signed [SW-1:0]  o_mixed_im;

    ncofs_tb_pkg::mix_scoreboard sb;
    int          send_idle_pct  = 38;
    int          recv_stall_pct = 87;
    int          hold_off_reqs  = 0;
    int unsigned cycle_count    = 0;
    int unsigned in_held_cycles = 0;

    nco_complex_frequency_shifter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_sample_re (i_sample_re),
        .i_sample_im (i_sample_im),
        .i_shift_hz  (i_shift_hz),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_mixed_re  (o_mixed_re),
        .o_mixed_im  (o_mixed_im)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watch both channels; inputs noted before outputs are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_input(i_action, i_sample_re, i_sample_im, i_shift_hz);
            if (i_valid && o_stall)
                in_held_cycles++;
            if (o_valid && !i_stall)
                sb.check_result(o_mixed_re, o_mixed_im);
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_reqs != hold_seen) begin
                hold_seen = hold_off_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d products pending", cycle_count, sb.pending());
        $display("nco_complex_frequency_shifter_top_tb failed");
        $finish;
    end

    // One input beat, with random idle cycles in front; returns once accepted
    task automatic send_beat(input logic act, input int sre, input int sim, input int shift);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_action    <= act;
        i_sample_re <= SW'(sre);
        i_sample_im <= SW'(sim);
        i_shift_hz  <= SHW'(shift);
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    function automatic int pick_sample();
        case ($urandom_range(9))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return int'($urandom);
        endcase
    endfunction

    // Mostly legal steps, some full-width words, small steps and eighth-turn multiples
    function automatic int pick_shift();
        case ($urandom_range(9))
            6: return int'($urandom);
            7: return int'($urandom_range(128)) - 64;
            8: return (int'($urandom_range(6)) - 3) * 24000;
            9: return $urandom_range(1) ? 95999 : -95999;
            default: return int'($urandom_range(191998)) - 95999;
        endcase
    endfunction

    task automatic run_random(input int n_beats);
        logic act;
        repeat (n_beats) begin
            act = ($urandom_range(99) < 15) ? ncofs_pkg::ACT_DISCARD : ncofs_pkg::ACT_MIX;
            send_beat(act, pick_sample(), pick_sample(), pick_shift());
        end
    endtask

    // Stop offering and wait for every pending product
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: exact cosine of one, quadrant edges, 45 degrees, overflow, discards
        send_beat(ncofs_pkg::ACT_MIX,     32767,      0,       0);
        send_beat(ncofs_pkg::ACT_MIX,    -32768, -32768,  -24000);
        send_beat(ncofs_pkg::ACT_DISCARD, 12345,     -1,   77777);
        send_beat(ncofs_pkg::ACT_MIX,     32767, -32768,  -24000);
        send_beat(ncofs_pkg::ACT_MIX,    -32768, -32768,  -48000);
        send_beat(ncofs_pkg::ACT_MIX,    -32768,  32767,  -48000);
        send_beat(ncofs_pkg::ACT_MIX,     32767,  32767,   95999);
        send_beat(ncofs_pkg::ACT_MIX,         0,      0,  -95999);
        send_beat(ncofs_pkg::ACT_MIX,        -1,      1, -131072);
        send_beat(ncofs_pkg::ACT_MIX,         1,     -1,  131071);
        send_beat(ncofs_pkg::ACT_MIX,    -32768,  32767,       1);
        send_beat(ncofs_pkg::ACT_DISCARD, -32768, -32768, -131072);
        send_beat(ncofs_pkg::ACT_MIX,     32767,  32767,  -48000);
        send_beat(ncofs_pkg::ACT_MIX,    -32768,      0,       0);
        send_beat(ncofs_pkg::ACT_MIX,         0, -32768,      -1);
        send_beat(ncofs_pkg::ACT_DISCARD, 32767,  32767,  131071);
        send_beat(ncofs_pkg::ACT_MIX,     21845, -21846,  -47999);
        send_beat(ncofs_pkg::ACT_MIX,    -32768, -32768,       0);
        settle();

        // Sender idles little, receiver stalls heavily
        run_random(500);
        settle();

        // Sender idles heavily, receiver stalls little
        send_idle_pct  = 87;
        recv_stall_pct = 38;
        run_random(500);
        settle();

        // Back to back, opening with a long output hold-off to fill the row
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_reqs <= hold_off_reqs + 1;
        run_random(500);
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d beats: %0d mixed, %0d discarded; %0d products checked",
                 sb.n_mixed + sb.n_discarded, sb.n_mixed, sb.n_discarded, sb.n_checked);
        $display("three idling profiles plus a %0d-cycle hold-off; input held off %0d cycles",
                 HOLD_CYCLES, in_held_cycles);
        if (sb.n_errors == 0) begin
            $display("nco_complex_frequency_shifter_top_tb passed");
        end else begin
            $display("%0d mismatches", sb.n_errors);
            $display("nco_complex_frequency_shifter_top_tb failed");
        end
        $finish;
    end

endmodule
